[rtl/core/csc_mv_pkg.sv]
// ----------------------------------------------------------------------------
// csc_mv_pkg
// Shared types and constants for the CSC sparse matrix-vector scatter block.
// ----------------------------------------------------------------------------
package csc_mv_pkg;

   localparam int ROWS_DEFAULT   = 1024;
   localparam int ROW_W          = 10;
   localparam int COUNT_W        = 11;
   localparam int COEF_W         = 32;
   localparam int ACC_W          = 48;
   localparam int PROD_W         = 2 * COEF_W;
   localparam int FRAC_W         = 24;
   // tag kept with every entry; a tag equal to the live epoch marks it valid
   localparam int EPOCH_W        = 4;
   localparam int WORD_W         = EPOCH_W + ACC_W;
   localparam int MAX_ROWS       = 1 << ROW_W;

   localparam logic [COUNT_W-1:0] ROW_COUNT_RESET = COUNT_W'(1024);
   localparam logic [ACC_W-1:0]   ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0]   ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef enum logic [1:0] {
      OP_PRESET = 2'd0,
      OP_ADD    = 2'd1,
      OP_READ   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_SAT   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ACC,
      ST_SWEEP
   } state_type;

   typedef struct packed {
      op_type                    op;
      logic [ROW_W-1:0]          row_index;
      logic signed [COEF_W-1:0]  coeff;
      logic signed [COEF_W-1:0]  x_value;
      logic signed [ACC_W-1:0]   write_value;
      logic                      last_of_pass;
   } req_type;

   typedef struct packed {
      logic signed [ACC_W-1:0]   read_value;
      status_type                status;
      logic                      pass_done;
   } rsp_type;

   typedef struct packed {
      logic load;   // capture product and base
      logic hit;    // entry tag matches live epoch
   } mac_ctl_type;

endpackage

[rtl/core/csc_mv_ram.sv]
// ----------------------------------------------------------------------------
// csc_mv_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module csc_mv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/csc_mv_mac.sv]
// ----------------------------------------------------------------------------
// csc_mv_mac
// Multiply stage and saturating accumulate for one nonzero contribution.
// ----------------------------------------------------------------------------
module csc_mv_mac (
   input  logic                                 clock,
   input  csc_mv_pkg::mac_ctl_type              ctl,
   input  logic signed [csc_mv_pkg::COEF_W-1:0] coeff,
   input  logic signed [csc_mv_pkg::COEF_W-1:0] x_value,
   input  logic [csc_mv_pkg::ACC_W-1:0]         entry_data,
   output logic [csc_mv_pkg::ACC_W-1:0]         base,
   output logic [csc_mv_pkg::ACC_W-1:0]         sum,
   output logic                                 sat
);
   import csc_mv_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic [ACC_W-1:0]         base_ff;
   logic [ACC_W:0]           wide_sum;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         prod_ff <= coeff * x_value;
         base_ff <= ctl.hit ? entry_data : '0;
      end
   end

   // round half up: bit 23 of the product is the carry-in of the shifted value
   always_comb begin
      wide_sum = {base_ff[ACC_W-1], base_ff}
               + {{(ACC_W+1-(PROD_W-FRAC_W)){prod_ff[PROD_W-1]}}, prod_ff[PROD_W-1:FRAC_W]}
               + {{ACC_W{1'b0}}, prod_ff[FRAC_W-1]};
      sat = wide_sum[ACC_W] != wide_sum[ACC_W-1];
      if (sat) begin
         sum = wide_sum[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         sum = wide_sum[ACC_W-1:0];
      end
   end

   assign base = base_ff;

endmodule

[rtl/core/sparse_csc_matvec_scatter.sv]
// ----------------------------------------------------------------------------
// sparse_csc_matvec_scatter
// Responses: the strobe is registered from the ACC state, which follows the LOAD
// state entered when start is taken. One command at a time (read, multiply, write
// back through the single result RAM); busy covers the load and accumulate states.
// Reset: synchronous; a tag sweep over min(ROWS,1024) entries (2 minimum) runs
// after reset and after every 15th clear, with busy high throughout.
// ----------------------------------------------------------------------------
module sparse_csc_matvec_scatter #(
   parameter int ROWS = csc_mv_pkg::ROWS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  csc_mv_pkg::req_type               req,
   output logic                              rsp_valid,
   output csc_mv_pkg::rsp_type               rsp,
   input  logic                              csr_wr_en,
   input  logic [csc_mv_pkg::COUNT_W-1:0]    csr_wr_data
);
   import csc_mv_pkg::*;

   localparam int MEM_DEPTH = (ROWS < 2) ? 2 : ((ROWS > MAX_ROWS) ? MAX_ROWS : ROWS);
   localparam int AW        = $clog2(MEM_DEPTH);
   localparam logic [AW-1:0]      SWEEP_LAST = AW'(MEM_DEPTH - 1);
   localparam logic [EPOCH_W-1:0] EPOCH_TOP  = {EPOCH_W{1'b1}};
   localparam logic [EPOCH_W-1:0] EPOCH_ONE  = EPOCH_W'(1);

   state_type               state_ff, state_in;
   req_type                 item_ff;
   logic                    in_range_ff, in_range_in;
   logic [EPOCH_W-1:0]      epoch_ff, epoch_in;
   logic [AW-1:0]           sweep_addr_ff, sweep_addr_in;
   logic [COUNT_W-1:0]      row_count_ff;
   rsp_type                 rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    accept;
   logic                    mem_we;
   logic [AW-1:0]           mem_waddr;
   logic [WORD_W-1:0]       mem_wdata;
   logic [WORD_W-1:0]       mem_rdata;
   mac_ctl_type             mac_ctl;
   logic [ACC_W-1:0]        mac_base, mac_sum;
   logic                    mac_sat;

   assign busy   = state_ff != ST_IDLE;
   assign accept = start && !busy;

   assign in_range_in = ({1'b0, req.row_index} < row_count_ff)
                     && (32'(req.row_index) < 32'(ROWS));

   csc_mv_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MEM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (accept),
      .rd_addr (req.row_index[AW-1:0]),
      .rd_data (mem_rdata)
   );

   assign mac_ctl.load = state_ff == ST_LOAD;
   assign mac_ctl.hit  = mem_rdata[WORD_W-1:ACC_W] == epoch_ff;

   csc_mv_mac u_mac (
      .clock      (clock),
      .ctl        (mac_ctl),
      .coeff      (item_ff.coeff),
      .x_value    (item_ff.x_value),
      .entry_data (mem_rdata[ACC_W-1:0]),
      .base       (mac_base),
      .sum        (mac_sum),
      .sat        (mac_sat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         epoch_ff      <= EPOCH_ONE;
         sweep_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         row_count_ff  <= ROW_COUNT_RESET;
      end else begin
         state_ff      <= state_in;
         epoch_ff      <= epoch_in;
         sweep_addr_ff <= sweep_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            row_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff     <= req;
         in_range_ff <= in_range_in;
      end
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      epoch_in      = epoch_ff;
      sweep_addr_in = sweep_addr_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_waddr     = item_ff.row_index[AW-1:0];
      mem_wdata     = {epoch_ff, item_ff.write_value};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            state_in          = ST_IDLE;
            rsp_valid_in      = 1'b1;
            rsp_in.read_value = '0;
            rsp_in.status     = STAT_OK;
            rsp_in.pass_done  = item_ff.last_of_pass;
            if (item_ff.op == OP_CLEAR) begin
               if (epoch_ff == EPOCH_TOP) begin
                  // tags would alias old entries: wipe them first
                  epoch_in      = EPOCH_ONE;
                  sweep_addr_in = '0;
                  state_in      = ST_SWEEP;
               end else begin
                  epoch_in = epoch_ff + EPOCH_ONE;
               end
            end else if (!in_range_ff) begin
               rsp_in.status = STAT_RANGE;
            end else begin
               case (item_ff.op)
                  OP_PRESET: begin
                     mem_we = 1'b1;
                  end
                  OP_READ: begin
                     rsp_in.read_value = mac_base;
                  end
                  OP_ADD: begin
                     if (item_ff.x_value != '0) begin
                        mem_we    = 1'b1;
                        mem_wdata = {epoch_ff, mac_sum};
                        if (mac_sat) begin
                           rsp_in.status = STAT_SAT;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            mem_we        = 1'b1;
            mem_waddr     = sweep_addr_ff;
            mem_wdata     = '0;
            sweep_addr_in = sweep_addr_ff + AW'(1);
            if (sweep_addr_ff == SWEEP_LAST) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

[rtl/core/csc_mv_checker.sv]
// ----------------------------------------------------------------------------
// csc_mv_checker
// Port-level checks for the CSC scatter block, bound to the top level.
// ----------------------------------------------------------------------------
module csc_mv_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic                              rsp_valid,
   input  csc_mv_pkg::rsp_type               rsp
);
   import csc_mv_pkg::*;

   // every response beat traces back to a command taken while not busy
   a_rsp_from_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 3))
      else $error("response beat without a matching command");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back response beats");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.status == STAT_OK || rsp.status == STAT_RANGE
                     || rsp.status == STAT_SAT))
      else $error("undefined status code");

   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.status != STAT_OK) |-> rsp.read_value == '0)
      else $error("nonzero read value on a rejected or saturated beat");

   // tag sweep holds off commands right after reset
   a_reset_busy: assert property (@(posedge clock)
      $fell(reset) |-> busy)
      else $error("ready immediately after reset");

endmodule

bind sparse_csc_matvec_scatter csc_mv_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp         (rsp)
);
